>>> hdl/mkd_pkg.sv
package mkd_pkg;

  localparam int TIME_W      = 24;
  localparam int MAX_SYMBOLS = 5;
  localparam int CODE_COUNT  = 36;
  localparam int CFG_AW      = 4;
  localparam int CFG_DW      = 32;

  localparam logic [TIME_W-1:0] DOT_MIN_RESET  = TIME_W'(50000);
  localparam logic [TIME_W-1:0] DASH_MIN_RESET = TIME_W'(250000);
  localparam logic [TIME_W-1:0] HOLD_MAX_RESET = TIME_W'(700000);
  localparam logic [TIME_W-1:0] GAP_MIN_RESET  = TIME_W'(400000);

  typedef enum logic [1:0] {
    REG_DOT_MIN  = 2'd0,
    REG_DASH_MIN = 2'd1,
    REG_HOLD_MAX = 2'd2,
    REG_GAP_MIN  = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_CHAR    = 3'd1,
    EV_NOMATCH = 3'd2,
    EV_TOOMANY = 3'd3,
    EV_HELD    = 3'd4
  } event_t;

  typedef enum logic [2:0] {
    K_DOT   = 3'd0,
    K_DASH  = 3'd1,
    K_HELD  = 3'd2,
    K_PRESS = 3'd3,
    K_GAP   = 3'd4,
    K_QUIET = 3'd5
  } kind_t;

  typedef struct packed {
    logic  found;
    logic [5:0] index;
  } lookup_t;

  localparam logic [2:0] CODE_LEN [CODE_COUNT] = '{
    3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5,
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2,
    3'd4, 3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3,
    3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
  };

  // Symbol k sits in bit k, a dash is a one.
  localparam logic [4:0] CODE_BITS [CODE_COUNT] = '{
    5'h1F, 5'h1E, 5'h1C, 5'h18, 5'h10, 5'h00, 5'h01, 5'h03, 5'h07, 5'h0F,
    5'h02, 5'h01, 5'h05, 5'h01, 5'h00, 5'h04, 5'h03, 5'h00, 5'h00,
    5'h0E, 5'h05, 5'h02, 5'h03, 5'h01, 5'h07, 5'h06, 5'h0B, 5'h02,
    5'h00, 5'h01, 5'h04, 5'h08, 5'h06, 5'h09, 5'h0D, 5'h03
  };

  function automatic lookup_t code_lookup(input logic [4:0] bits, input logic [2:0] count);
    lookup_t res;
    res = '0;
    for (int i = CODE_COUNT - 1; i >= 0; i--) begin
      if (CODE_LEN[i] == count && CODE_BITS[i] == bits) begin
        res.found = 1'b1;
        res.index = 6'(i);
      end
    end
    return res;
  endfunction

endpackage

>>> hdl/mkd_if.sv
interface mkd_in_if import mkd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [TIME_W-1:0] duration_us;

  modport source (output valid, output operation, output duration_us, input ready);
  modport sink (input valid, input operation, input duration_us, output ready);
endinterface

interface mkd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [5:0] char_index;

  modport source (output valid, output event_res, output char_index, input ready);
  modport sink (input valid, input event_res, input char_index, output ready);
endinterface

>>> hdl/mkd_front.sv
module mkd_front import mkd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  mkd_in_if.sink            in_ch,
  output logic              push_valid,
  input  logic              push_ready,
  output kind_t             push_kind
);

  logic [TIME_W-1:0] dot_min_r;
  logic [TIME_W-1:0] dash_min_r;
  logic [TIME_W-1:0] hold_max_r;
  logic [TIME_W-1:0] gap_min_r;
  reg_idx_t          reg_sel;
  logic              wr_en;
  logic [TIME_W-1:0] wr_val;
  logic [TIME_W-1:0] rd_val;
  logic [TIME_W-1:0] dur;
  logic              is_dot;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;
  assign wr_val  = pwdata[TIME_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_min_r  <= DOT_MIN_RESET;
      dash_min_r <= DASH_MIN_RESET;
      hold_max_r <= HOLD_MAX_RESET;
      gap_min_r  <= GAP_MIN_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_DOT_MIN:  dot_min_r  <= wr_val;
        REG_DASH_MIN: dash_min_r <= wr_val;
        REG_HOLD_MAX: hold_max_r <= wr_val;
        REG_GAP_MIN:  gap_min_r  <= wr_val;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_DOT_MIN:  rd_val = dot_min_r;
      REG_DASH_MIN: rd_val = dash_min_r;
      REG_HOLD_MAX: rd_val = hold_max_r;
      REG_GAP_MIN:  rd_val = gap_min_r;
      default:      rd_val = '0;
    endcase
  end

  assign prdata = CFG_DW'(rd_val);

  assign dur        = in_ch.duration_us;
  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;
  assign is_dot      = (dur > dot_min_r) && (dur < dash_min_r);

  always_comb begin
    if (in_ch.operation) begin
      push_kind = (dur > gap_min_r) ? K_GAP : K_QUIET;
    end else begin
      priority if (is_dot) begin
        push_kind = K_DOT;
      end else if (dur > hold_max_r) begin
        push_kind = K_HELD;
      end else if (dur > dash_min_r) begin
        push_kind = K_DASH;
      end else begin
        push_kind = K_PRESS;
      end
    end
  end

endmodule

>>> hdl/mkd_queue.sv
module mkd_queue import mkd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  kind_t push_kind,
  output logic  pop_valid,
  input  logic  pop_ready,
  output kind_t pop_kind
);

  kind_t      mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_kind   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

>>> hdl/mkd_back.sv
module mkd_back import mkd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  pop_valid,
  output logic  pop_ready,
  input  kind_t pop_kind,
  mkd_out_if.source out_ch
);

  logic [4:0] bits_r;
  logic [4:0] bits_nxt;
  logic [2:0] count_r;
  logic [2:0] count_nxt;
  logic       armed_r;
  logic       armed_nxt;
  logic       valid_r;
  event_t     ev_r;
  event_t     ev_nxt;
  logic [5:0] ch_r;
  logic [5:0] ch_nxt;
  logic       take;
  logic       add_en;
  logic       add_dash;
  lookup_t    hit;

  assign pop_ready = !valid_r || out_ch.ready;
  assign take      = pop_valid && pop_ready;
  assign hit       = code_lookup(bits_r, count_r);

  always_comb begin
    bits_nxt  = bits_r;
    count_nxt = count_r;
    armed_nxt = armed_r;
    ev_nxt    = EV_NONE;
    ch_nxt    = '0;
    add_en    = 1'b0;
    add_dash  = 1'b0;
    unique case (pop_kind)
      K_DOT: begin
        armed_nxt = 1'b1;
        add_en    = 1'b1;
      end
      K_DASH: begin
        armed_nxt = 1'b1;
        add_en    = 1'b1;
        add_dash  = 1'b1;
      end
      K_HELD: begin
        armed_nxt = 1'b1;
        bits_nxt  = '0;
        count_nxt = '0;
        ev_nxt    = EV_HELD;
      end
      K_PRESS: begin
        armed_nxt = 1'b1;
      end
      K_GAP: begin
        if (armed_r) begin
          if (count_r > 3'(MAX_SYMBOLS)) begin
            ev_nxt = EV_TOOMANY;
          end else if (hit.found) begin
            ev_nxt = EV_CHAR;
            ch_nxt = hit.index;
          end else begin
            ev_nxt = EV_NOMATCH;
          end
          bits_nxt  = '0;
          count_nxt = '0;
          armed_nxt = 1'b0;
        end
      end
      default: ;
    endcase
    if (add_en) begin
      if (count_r < 3'(MAX_SYMBOLS)) begin
        bits_nxt  = bits_r | (5'(add_dash) << count_r);
        count_nxt = count_r + 3'd1;
      end else begin
        count_nxt = 3'(MAX_SYMBOLS + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r  <= '0;
      count_r <= '0;
      armed_r <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      if (take) begin
        bits_r  <= bits_nxt;
        count_r <= count_nxt;
        armed_r <= armed_nxt;
        valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ev_r <= ev_nxt;
      ch_r <= ch_nxt;
    end
  end

  assign out_ch.valid      = valid_r;
  assign out_ch.event_res  = ev_r;
  assign out_ch.char_index = ch_r;

endmodule

>>> hdl/morse_key_decoder.sv
// A transaction accepted at the input goes through the queue into the back end's output
// register. Throughput: one transaction per cycle while the output is ready, set by the
// back end's state update; a two-entry queue lets input and output stall independently.
// Reset: synchronous, active low; thresholds return to their defaults, symbols and
// the armed flag clear, and the queue and output register empty.
module morse_key_decoder import mkd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  mkd_in_if.sink            in_ch,
  mkd_out_if.source         out_ch
);

  logic  push_valid;
  logic  push_ready;
  kind_t push_kind;
  logic  pop_valid;
  logic  pop_ready;
  kind_t pop_kind;

  mkd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_kind  (push_kind)
  );

  mkd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_kind  (push_kind),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_kind   (pop_kind)
  );

  mkd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_kind  (pop_kind),
    .out_ch    (out_ch)
  );

endmodule

>>> sim/morse_score_pkg.sv
package morse_score_pkg;
  import mkd_pkg::*;

  typedef struct packed {
    event_t     ev;
    logic [5:0] index;
  } key_result_t;

  class key_decode_model;
    string             codes [36];
    logic [TIME_W-1:0] dot_min;
    logic [TIME_W-1:0] dash_min;
    logic [TIME_W-1:0] hold_max;
    logic [TIME_W-1:0] gap_min;
    logic [4:0]        sym_bits;
    logic [2:0]        sym_count;
    bit                armed;
    key_result_t       letters_due [$];
    int unsigned       errors;
    int unsigned       checked;
    int unsigned       ev_seen [5];

    function new();
      codes = '{"-----", ".----", "..---", "...--", "....-",
                ".....", "-....", "--...", "---..", "----.",
                ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
                ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.",
                "...", "-", "..-", "...-", ".--", "-..-", "-.--", "--.."};
      dot_min   = DOT_MIN_RESET;
      dash_min  = DASH_MIN_RESET;
      hold_max  = HOLD_MAX_RESET;
      gap_min   = GAP_MIN_RESET;
      sym_bits  = '0;
      sym_count = '0;
      armed     = 1'b0;
      errors    = 0;
      checked   = 0;
      foreach (ev_seen[i]) ev_seen[i] = 0;
    endfunction

    function void set_reg(reg_idx_t r, logic [TIME_W-1:0] v);
      case (r)
        REG_DOT_MIN:  dot_min = v;
        REG_DASH_MIN: dash_min = v;
        REG_HOLD_MAX: hold_max = v;
        REG_GAP_MIN:  gap_min = v;
        default: ;
      endcase
    endfunction

    function void add_symbol(bit dash);
      if (sym_count < 3'(MAX_SYMBOLS)) begin
        sym_bits[sym_count] = dash;
        sym_count = sym_count + 3'd1;
      end else begin
        sym_count = 3'(MAX_SYMBOLS + 1);
      end
    endfunction

    function int find_code();
      bit hit;
      for (int i = 0; i < 36; i++) begin
        if (codes[i].len() == int'(sym_count)) begin
          hit = 1'b1;
          for (int k = 0; k < codes[i].len(); k++) begin
            if (sym_bits[k] != (codes[i][k] == "-")) hit = 1'b0;
          end
          if (hit) return i;
        end
      end
      return -1;
    endfunction

    function void note_key(bit op, logic [TIME_W-1:0] dur);
      key_result_t r;
      int          idx;
      r.ev    = EV_NONE;
      r.index = '0;
      if (!op) begin
        armed = 1'b1;
        if (dur > dot_min && dur < dash_min) begin
          add_symbol(1'b0);
        end else if (dur > hold_max) begin
          sym_bits  = '0;
          sym_count = '0;
          r.ev      = EV_HELD;
        end else if (dur > dash_min) begin
          add_symbol(1'b1);
        end
      end else if (dur > gap_min && armed) begin
        if (sym_count > 3'(MAX_SYMBOLS)) begin
          r.ev = EV_TOOMANY;
        end else begin
          idx = find_code();
          if (idx >= 0) begin
            r.ev    = EV_CHAR;
            r.index = 6'(idx);
          end else begin
            r.ev = EV_NOMATCH;
          end
        end
        sym_bits  = '0;
        sym_count = '0;
        armed     = 1'b0;
      end
      letters_due.push_back(r);
    endfunction

    task report(string what);
      $display("MISMATCH: %s", what);
      errors++;
    endtask

    task check_result(logic [2:0] ev, logic [5:0] index);
      key_result_t r;
      if (letters_due.size() == 0) begin
        report($sformatf("unexpected result event %0d index %0d", ev, index));
      end else begin
        r = letters_due.pop_front();
        checked++;
        ev_seen[r.ev]++;
        if (ev !== r.ev)
          report($sformatf("result %0d: event %0d, want %s", checked, ev, r.ev.name()));
        if (index !== r.index)
          report($sformatf("result %0d: index %0d, want %0d", checked, index, r.index));
      end
    endtask

    function int pending();
      return letters_due.size();
    endfunction
  endclass

endpackage

>>> sim/tb_morse_key_decoder.sv
module tb_morse_key_decoder import mkd_pkg::*, morse_score_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TIME_SPAN = 1 << TIME_W;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  mkd_in_if  in_if ();
  mkd_out_if out_if ();

  morse_key_decoder u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_ch   (in_if),
    .out_ch  (out_if)
  );

  key_decode_model decode_model = new();
  int              idle_pct = 0;
  int              stall_pct = 0;
  int unsigned     keys_sent = 0;
  int unsigned     settings_used = 1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin : watchdog
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : receiver
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready)
        decode_model.check_result(out_if.event_res, out_if.char_index);
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic [TIME_W-1:0] pick_between(int unsigned lo, int unsigned hi);
    if (hi > lo + 1) return TIME_W'($urandom_range(hi - 1, lo + 1));
    return TIME_W'($urandom);
  endfunction

  function automatic logic [TIME_W-1:0] dot_len();
    return pick_between(32'(decode_model.dot_min), 32'(decode_model.dash_min));
  endfunction

  function automatic logic [TIME_W-1:0] dash_len();
    return pick_between(32'(decode_model.dash_min), 32'(decode_model.hold_max) + 1);
  endfunction

  function automatic logic [TIME_W-1:0] held_len();
    return pick_between(32'(decode_model.hold_max), TIME_SPAN);
  endfunction

  function automatic logic [TIME_W-1:0] gap_len();
    return pick_between(32'(decode_model.gap_min), TIME_SPAN);
  endfunction

  function automatic logic [TIME_W-1:0] boundary_len();
    logic [TIME_W-1:0] t;
    case ($urandom_range(5))
      0: t = decode_model.dot_min;
      1: t = decode_model.dash_min;
      2: t = decode_model.hold_max;
      3: t = decode_model.gap_min;
      4: t = '0;
      default: t = '1;
    endcase
    return t + TIME_W'($urandom_range(2)) - TIME_W'(1);
  endfunction

  task automatic send_key(bit op, logic [TIME_W-1:0] dur);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.operation   <= op;
    in_if.duration_us <= dur;
    do @(posedge clk); while (!in_if.ready);
    decode_model.note_key(op, dur);
    keys_sent++;
  endtask

  task automatic send_symbols(bit [6:0] dashes, int count);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(9) == 0) send_key(1'b0, boundary_len());
      send_key(1'b0, dashes[k] ? dash_len() : dot_len());
    end
    send_key(1'b1, gap_len());
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (decode_model.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t r, logic [TIME_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'({r, 2'b00});
    pwdata  <= {8'($urandom), v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    decode_model.set_reg(r, v);
  endtask

  task automatic set_thresholds(logic [TIME_W-1:0] dot, logic [TIME_W-1:0] dash,
                                logic [TIME_W-1:0] hold, logic [TIME_W-1:0] gap);
    write_reg(REG_DOT_MIN, dot);
    write_reg(REG_DASH_MIN, dash);
    write_reg(REG_HOLD_MAX, hold);
    write_reg(REG_GAP_MIN, gap);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  task automatic run_random(int unsigned stop_at);
    int          pick;
    int unsigned ci;
    bit [6:0]    pattern;
    while (keys_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        ci      = $urandom_range(35);
        pattern = '0;
        for (int k = 0; k < decode_model.codes[ci].len(); k++)
          pattern[k] = (decode_model.codes[ci][k] == "-");
        send_symbols(pattern, decode_model.codes[ci].len());
      end else if (pick < 70) begin
        send_symbols(7'($urandom), $urandom_range(7));
      end else begin
        case ($urandom_range(3))
          0: send_key(1'($urandom), TIME_W'($urandom));
          1: send_key(1'($urandom), boundary_len());
          2: send_key(1'b0, held_len());
          default: send_key(1'b1, gap_len());
        endcase
      end
    end
  endtask

  initial begin : stimulus
    rst_n             <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    in_if.valid       <= 1'b0;
    in_if.operation   <= 1'b0;
    in_if.duration_us <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed keying at the reset thresholds.
    send_key(1'b1, '1);
    send_key(1'b0, '0);
    send_key(1'b1, 24'd400001);
    send_key(1'b0, 24'd50001);
    send_key(1'b0, 24'd249999);
    send_key(1'b0, 24'd250000);
    send_key(1'b0, 24'd50000);
    send_key(1'b0, 24'd700000);
    send_key(1'b1, 24'd400000);
    send_key(1'b1, '1);
    send_key(1'b0, 24'd250001);
    send_key(1'b0, '1);
    send_key(1'b1, 24'd400001);
    repeat (6) send_key(1'b0, 24'd100000);
    send_key(1'b1, 24'd500000);
    repeat (5) send_key(1'b0, 24'd300000);
    send_key(1'b1, 24'd400001);

    for (int p = 0; p < 6; p++) begin
      drain();
      case (p)
        1: set_thresholds(24'd10, 24'd30, 24'd60, 24'd40);
        2: set_thresholds('0, '1, '1, '0);
        3: set_thresholds('1, '0, '0, '1);
        4: set_thresholds(24'd100, 24'd50, 24'd200, 24'd5);
        5: set_thresholds(24'd50000, 24'd250000, 24'd700000, 24'd400000);
        default: ;
      endcase
      case (p)
        1, 4: begin
          idle_pct  = 61;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 61;
        end
        3: begin
          idle_pct  = 25;
          stall_pct = 25;
        end
        default: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
      endcase
      run_random(keys_sent + 200);
    end

    drain();
    repeat (10) @(posedge clk);
    $display("Checked %0d results from %0d key events under %0d threshold settings.",
             decode_model.checked, keys_sent, settings_used);
    $display("Characters %0d, no match %0d, too many symbols %0d, held too long %0d.",
             decode_model.ev_seen[EV_CHAR], decode_model.ev_seen[EV_NOMATCH],
             decode_model.ev_seen[EV_TOOMANY], decode_model.ev_seen[EV_HELD]);
    if (decode_model.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/mkd_pkg.sv
hdl/mkd_if.sv
hdl/mkd_front.sv
hdl/mkd_queue.sv
hdl/mkd_back.sv
hdl/morse_key_decoder.sv
sim/morse_score_pkg.sv
sim/tb_morse_key_decoder.sv
